[rtl/kmc_pkg.sv]
`default_nettype none
package kmc_pkg;

  localparam int MAX_POINTS   = 4096;
  localparam int PTR_W        = $clog2(MAX_POINTS);
  localparam int CNT_W        = PTR_W + 1;
  localparam int MAX_CLUSTERS = 16;
  localparam int CL_W         = $clog2(MAX_CLUSTERS);
  localparam int K_W          = CL_W + 1;
  localparam int SUM_W        = 32 + CNT_W - 1;
  localparam int DIST_W       = 34;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_RUN   = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_CENTROID = 2'd0,
    KIND_MEMBER   = 2'd1,
    KIND_ERROR    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_FEW      = 2'd1,
    ERR_FULL     = 2'd2,
    ERR_RANGE    = 2'd3
  } err_t;

  localparam logic [1:0] REG_CLUSTER_COUNT  = 2'd0;
  localparam logic [1:0] REG_MOVE_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_MAX_ITERATIONS = 2'd2;

  localparam logic [4:0]  CLUSTER_COUNT_RST  = 5'd4;
  localparam logic [30:0] MOVE_THRESHOLD_RST = 31'd66;
  localparam logic [15:0] MAX_ITERATIONS_RST = 16'd100;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [CL_W-1:0]    cluster_index;
    logic signed [31:0] centroid_x;
    logic signed [31:0] centroid_y;
    logic signed [31:0] centroid_z;
    logic [CNT_W-1:0]   member_count;
    logic [30:0]        member_id;
    logic               converged;
    logic [15:0]        iterations_used;
    logic [1:0]         error_code;
    logic               last;
  } result_t;

endpackage
`default_nettype wire

[rtl/kmc_if.sv]
`default_nettype none
interface kmc_cmd_if import kmc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic [30:0]        point_id;
  logic [PTR_W-1:0]   point_index;
  modport source (output valid, operation, point_x, point_y, point_z, point_id,
                  point_index, input ready);
  modport sink (input valid, operation, point_x, point_y, point_z, point_id,
                point_index, output ready);
endinterface

interface kmc_res_if import kmc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic [CL_W-1:0]    cluster_index;
  logic signed [31:0] centroid_x;
  logic signed [31:0] centroid_y;
  logic signed [31:0] centroid_z;
  logic [CNT_W-1:0]   member_count;
  logic [30:0]        member_id;
  logic               converged;
  logic [15:0]        iterations_used;
  logic [1:0]         error_code;
  logic               last;
  modport source (output valid, result_kind, cluster_index, centroid_x, centroid_y,
                  centroid_z, member_count, member_id, converged, iterations_used,
                  error_code, last, input ready);
  modport sink (input valid, result_kind, cluster_index, centroid_x, centroid_y,
                centroid_z, member_count, member_id, converged, iterations_used,
                error_code, last, output ready);
endinterface

interface kmc_cfg_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [30:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/kmc_div.sv]
`default_nettype none
// signed truncating divide, one quotient bit per cycle
module kmc_div import kmc_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [SUM_W-1:0] dividend,
  input  wire logic [CNT_W-1:0]        divisor,
  output logic                         done,
  output logic signed [31:0]           quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic              neg;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W:0]    rem;
  logic [CNT_W-1:0]  dvs;
  logic [CNT_W:0]    rem_sh;
  logic [SUM_W-1:0]  mag;
  logic [SUM_W-1:0]  signed_quo;

  assign rem_sh     = {rem[CNT_W-1:0], quo[SUM_W-1]};
  assign mag        = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
  assign signed_quo = neg ? SUM_W'(-quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        neg  <= dividend[SUM_W-1];
        quo  <= mag;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (rem_sh >= {1'b0, dvs}) begin
          rem <= rem_sh - {1'b0, dvs};
          quo <= {quo[SUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[SUM_W-2:0], 1'b0};
        end
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // mean of 32-bit values always fits 32 bits
  assign quotient = signed_quo[31:0];

endmodule
`default_nettype wire

[rtl/kmeans_manhattan_cluster_3d_core.sv]
`default_nettype none
// k-means clustering of 3d points by manhattan distance
// cmd channel: one word per command (load, run, query, clear); ready is high
// only while the block is idle. result channel: words held in an output
// register until taken; a stalled receiver simply holds the sequencer.
// cfg channel: always ready; write only while idle.
// load and clear give no word (a load into a full store gives one error
// word). a query answer word is built from the registered store read and
// is then held in the output register.
// a run seeds k centroids (a store read and a write each), then each iteration
// assigns every point to its nearest centroid and, per non-empty cluster,
// runs three divides through the one shared serial divider; after the
// last iteration k centroid words follow, one per accepted word.
// the point store is single-ported memory; its read data is registered.
// reset clears the point count, centroids and registers to their defaults;
// store contents are left as they are.
module kmeans_manhattan_cluster_3d_core import kmc_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  kmc_cmd_if.sink   cmd,
  kmc_res_if.source result,
  kmc_cfg_if.sink   cfg
);

  typedef enum logic [3:0] {
    S_IDLE, S_SEED_RD, S_SEED_WR, S_QUERY, S_IT_START, S_P_RD, S_DIST, S_CMP,
    S_ACC, S_UPD, S_DIV, S_MOVE, S_ONE_OUT, S_REPORT
  } state_t;

  state_t state;

  logic [4:0]  cluster_count;
  logic [30:0] move_threshold;
  logic [15:0] max_iterations;

  logic signed [31:0] store_x [MAX_POINTS];
  logic signed [31:0] store_y [MAX_POINTS];
  logic signed [31:0] store_z [MAX_POINTS];
  logic [30:0]        store_id [MAX_POINTS];
  logic [CL_W-1:0]    assignment [MAX_POINTS];

  logic signed [31:0] rd_x, rd_y, rd_z;
  logic [30:0]        rd_id;
  logic [CL_W-1:0]    rd_asg;
  logic               rd_en;
  logic [PTR_W-1:0]   rd_addr;

  logic [CNT_W-1:0]   point_count;
  logic signed [31:0] cx [MAX_CLUSTERS];
  logic signed [31:0] cy [MAX_CLUSTERS];
  logic signed [31:0] cz [MAX_CLUSTERS];
  logic signed [SUM_W-1:0] sx [MAX_CLUSTERS];
  logic signed [SUM_W-1:0] sy [MAX_CLUSTERS];
  logic signed [SUM_W-1:0] sz [MAX_CLUSTERS];
  logic [CNT_W-1:0]   members [MAX_CLUSTERS];

  logic [K_W-1:0]     k;
  logic [15:0]        cap;
  logic [15:0]        iters;
  logic               moved;
  logic [PTR_W-1:0]   pi;
  logic [CL_W-1:0]    cj;
  logic [CL_W-1:0]    best;
  logic [DIST_W-1:0]  bestd;
  logic [31:0]        ad_x, ad_y, ad_z;
  logic [1:0]         axis;
  logic signed [31:0] nq [3];
  result_t            res;
  logic               res_valid;

  logic               div_start;
  logic               div_done;
  logic signed [SUM_W-1:0] div_num;
  logic signed [31:0] div_q;

  logic               cmd_acc;
  logic               res_acc;
  logic [K_W-1:0]     k_eff;
  logic [15:0]        cap_eff;
  logic [DIST_W-1:0]  pt_dist;
  logic               last_cl;
  logic signed [32:0] dmx, dmy, dmz;
  logic [32:0]        amx, amy, amz;
  logic               move_now;
  logic signed [32:0] dx, dy, dz;

  function automatic result_t err_word(err_t code);
    result_t r;
    r = '0;
    r.result_kind = KIND_ERROR;
    r.error_code  = code;
    r.last        = 1'b1;
    return r;
  endfunction

  function automatic result_t member_word(logic [CL_W-1:0] cl, logic [30:0] id);
    result_t r;
    r = '0;
    r.result_kind   = KIND_MEMBER;
    r.cluster_index = cl;
    r.member_id     = id;
    r.last          = 1'b1;
    return r;
  endfunction

  function automatic result_t cent_word(logic [CL_W-1:0] cl, logic fin);
    result_t r;
    r = '0;
    r.result_kind     = KIND_CENTROID;
    r.cluster_index   = cl;
    r.centroid_x      = cx[cl];
    r.centroid_y      = cy[cl];
    r.centroid_z      = cz[cl];
    r.member_count    = members[cl];
    r.converged       = !moved;
    r.iterations_used = iters;
    r.last            = fin;
    return r;
  endfunction

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign res_acc   = res_valid && result.ready;

  assign k_eff = (cluster_count == 5'd0) ? K_W'(1) :
                 (cluster_count > 5'(MAX_CLUSTERS)) ? K_W'(MAX_CLUSTERS) :
                 K_W'(cluster_count);
  assign cap_eff = (max_iterations == 16'd0) ? 16'd1 : max_iterations;
  assign last_cl = ({1'b0, cj} == k - 1'b1);

  // distance terms against centroid cj
  assign dx      = 33'(cx[cj]) - 33'(rd_x);
  assign dy      = 33'(cy[cj]) - 33'(rd_y);
  assign dz      = 33'(cz[cj]) - 33'(rd_z);
  assign pt_dist = DIST_W'(ad_x) + DIST_W'(ad_y) + DIST_W'(ad_z);

  // movement test of the new mean
  assign dmx = 33'(nq[0]) - 33'(cx[cj]);
  assign dmy = 33'(nq[1]) - 33'(cy[cj]);
  assign dmz = 33'(nq[2]) - 33'(cz[cj]);
  assign amx = dmx[32] ? 33'(-dmx) : 33'(dmx);
  assign amy = dmy[32] ? 33'(-dmy) : 33'(dmy);
  assign amz = dmz[32] ? 33'(-dmz) : 33'(dmz);
  assign move_now = (amx > {2'b0, move_threshold}) || (amy > {2'b0, move_threshold}) ||
                    (amz > {2'b0, move_threshold});

  always_comb begin
    case (axis)
      2'd0:    div_num = sx[cj];
      2'd1:    div_num = sy[cj];
      default: div_num = sz[cj];
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pi;
    case (state)
      S_IDLE: begin
        rd_en   = cmd_acc && (cmd.operation == OP_QUERY);
        rd_addr = cmd.point_index;
      end
      S_SEED_RD: begin
        rd_en   = 1'b1;
        rd_addr = PTR_W'(cj);
      end
      S_P_RD: begin
        rd_en = 1'b1;
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_x   <= store_x[rd_addr];
      rd_y   <= store_y[rd_addr];
      rd_z   <= store_z[rd_addr];
      rd_id  <= store_id[rd_addr];
      rd_asg <= assignment[rd_addr];
    end
    if (state == S_IDLE && cmd_acc && cmd.operation == OP_LOAD &&
        point_count != CNT_W'(MAX_POINTS)) begin
      store_x[point_count[PTR_W-1:0]]    <= cmd.point_x;
      store_y[point_count[PTR_W-1:0]]    <= cmd.point_y;
      store_z[point_count[PTR_W-1:0]]    <= cmd.point_z;
      store_id[point_count[PTR_W-1:0]]   <= cmd.point_id;
      assignment[point_count[PTR_W-1:0]] <= '0;
    end else if (state == S_ACC) begin
      assignment[pi] <= best;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count  <= CLUSTER_COUNT_RST;
      move_threshold <= MOVE_THRESHOLD_RST;
      max_iterations <= MAX_ITERATIONS_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_CLUSTER_COUNT:  cluster_count  <= cfg.data[4:0];
        REG_MOVE_THRESHOLD: move_threshold <= cfg.data;
        REG_MAX_ITERATIONS: max_iterations <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  kmc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (members[cj]),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= '0;
      res_valid   <= 1'b0;
      div_start   <= 1'b0;
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
        cx[c] <= '0;
        cy[c] <= '0;
        cz[c] <= '0;
      end
    end else begin
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            case (op_t'(cmd.operation))
              OP_LOAD: begin
                if (point_count == CNT_W'(MAX_POINTS)) begin
                  res       <= err_word(ERR_FULL);
                  res_valid <= 1'b1;
                  state     <= S_ONE_OUT;
                end else begin
                  point_count <= point_count + 1'b1;
                end
              end
              OP_RUN: begin
                k     <= k_eff;
                cap   <= cap_eff;
                iters <= '0;
                cj    <= '0;
                if (point_count < CNT_W'(k_eff)) begin
                  res       <= err_word(ERR_FEW);
                  res_valid <= 1'b1;
                  state     <= S_ONE_OUT;
                end else begin
                  state <= S_SEED_RD;
                end
              end
              OP_QUERY: begin
                if ({1'b0, cmd.point_index} >= point_count) begin
                  res       <= err_word(ERR_RANGE);
                  res_valid <= 1'b1;
                  state     <= S_ONE_OUT;
                end else begin
                  state <= S_QUERY;
                end
              end
              default: point_count <= '0;
            endcase
          end
        end
        S_QUERY: begin
          res       <= member_word(rd_asg, rd_id);
          res_valid <= 1'b1;
          state     <= S_ONE_OUT;
        end
        S_SEED_RD: state <= S_SEED_WR;
        S_SEED_WR: begin
          cx[cj] <= rd_x;
          cy[cj] <= rd_y;
          cz[cj] <= rd_z;
          cj     <= cj + 1'b1;
          state  <= last_cl ? S_IT_START : S_SEED_RD;
        end
        S_IT_START: begin
          for (int c = 0; c < MAX_CLUSTERS; c++) begin
            sx[c]      <= '0;
            sy[c]      <= '0;
            sz[c]      <= '0;
            members[c] <= '0;
          end
          moved <= 1'b0;
          pi    <= '0;
          state <= S_P_RD;
        end
        S_P_RD: begin
          cj    <= '0;
          state <= S_DIST;
        end
        S_DIST: begin
          ad_x  <= dx[32] ? 32'(-dx) : dx[31:0];
          ad_y  <= dy[32] ? 32'(-dy) : dy[31:0];
          ad_z  <= dz[32] ? 32'(-dz) : dz[31:0];
          state <= S_CMP;
        end
        S_CMP: begin
          // ties keep the lower index
          if (cj == '0 || pt_dist < bestd) begin
            best  <= cj;
            bestd <= pt_dist;
          end
          cj    <= cj + 1'b1;
          state <= last_cl ? S_ACC : S_DIST;
        end
        S_ACC: begin
          sx[best]      <= sx[best] + SUM_W'(rd_x);
          sy[best]      <= sy[best] + SUM_W'(rd_y);
          sz[best]      <= sz[best] + SUM_W'(rd_z);
          members[best] <= members[best] + 1'b1;
          pi            <= pi + 1'b1;
          if ({1'b0, pi} == point_count - 1'b1) begin
            cj    <= '0;
            state <= S_UPD;
          end else begin
            state <= S_P_RD;
          end
        end
        S_UPD: begin
          if (members[cj] == '0) begin
            // empty cluster keeps its centroid
            if (last_cl) begin
              cj    <= '0;
              iters <= iters + 1'b1;
              state <= S_REPORT;
            end else begin
              cj <= cj + 1'b1;
            end
          end else begin
            axis      <= 2'd0;
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            nq[axis] <= div_q;
            if (axis == 2'd2) begin
              state <= S_MOVE;
            end else begin
              axis      <= axis + 1'b1;
              div_start <= 1'b1;
            end
          end
        end
        S_MOVE: begin
          if (move_now) begin
            cx[cj] <= nq[0];
            cy[cj] <= nq[1];
            cz[cj] <= nq[2];
          end
          if (last_cl) begin
            cj    <= '0;
            iters <= iters + 1'b1;
            moved <= moved || move_now;
            state <= S_REPORT;
          end else begin
            cj    <= cj + 1'b1;
            moved <= moved || move_now;
            state <= S_UPD;
          end
        end
        S_REPORT: begin
          // first visit after an iteration decides whether to loop
          if (!res_valid) begin
            if (moved && iters < cap) begin
              state <= S_IT_START;
            end else begin
              res       <= cent_word(cj, last_cl);
              res_valid <= 1'b1;
            end
          end else if (res_acc) begin
            if (res.last) begin
              res_valid <= 1'b0;
              state     <= S_IDLE;
            end else begin
              res <= cent_word(cj + 1'b1, ({1'b0, cj} + 1'b1 == k - 1'b1));
              cj  <= cj + 1'b1;
            end
          end
        end
        S_ONE_OUT: begin
          if (res_acc) begin
            res_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid           = res_valid;
  assign result.result_kind     = res.result_kind;
  assign result.cluster_index   = res.cluster_index;
  assign result.centroid_x      = res.centroid_x;
  assign result.centroid_y      = res.centroid_y;
  assign result.centroid_z      = res.centroid_z;
  assign result.member_count    = res.member_count;
  assign result.member_id       = res.member_id;
  assign result.converged       = res.converged;
  assign result.iterations_used = res.iterations_used;
  assign result.error_code      = res.error_code;
  assign result.last            = res.last;

  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !result.valid) else $error("command taken while a word is pending");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.result_kind == KIND_ERROR |-> result.last)
    else $error("error word not marked last");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_W'(MAX_POINTS)) else $error("point count beyond store size");
  a_iter_cap: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.result_kind == KIND_CENTROID |->
    result.iterations_used != 16'd0) else $error("centroid report with no iteration");

endmodule
`default_nettype wire
